// ----- rtl/indexed_linked_list_table_defines.svh -----
// Assertion macros for the indexed linked-list table.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef INDEXED_LINKED_LIST_TABLE_DEFINES_SVH
`define INDEXED_LINKED_LIST_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILLT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("illt check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define ILLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("illt check failed: next-cycle rule");

`endif

// ----- rtl/illt_pkg.sv -----
// Shared types and constants of the indexed linked-list table.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package illt_pkg;

    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 10;
    localparam int SIZE_W  = 11;

    localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 11'd1024;

    // Operation codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_LINK  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic clr;       // write zeros at the clear pointer, advance it
        logic accept;    // capture the input word, read the slot's links
        logic check;     // register the status of the current word
        logic step1;     // first pair of link writes, member count update
        logic step2;     // second pair of link writes
        logic load_out;  // move the result into the output register
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;  // clear pointer at the last slot
        logic fail;      // current word is refused
        logic out_free;  // output register can take a word this cycle
    } t_ctl_stat;

endpackage

`default_nettype wire

// ----- rtl/illt_ctrl.sv -----
// Sequencer of the indexed linked-list table: clear pass, check, link writes.
// Depends on illt_pkg; drives the datapath through t_ctl_cmd.
`default_nettype none

module illt_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  illt_pkg::t_ctl_stat  i_stat,
    output illt_pkg::t_ctl_cmd   o_cmd
);
    import illt_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_WR2   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                o_cmd.step1 = !i_stat.fail;
                n_state     = i_stat.fail ? S_DONE : S_WR2;
            end
            S_WR2: begin
                o_cmd.step2 = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

endmodule

`default_nettype wire

// ----- rtl/illt_datapath.sv -----
// Datapath of the indexed linked-list table: link memories, sentinel
// registers, member count, size register and output register. Uses illt_pkg.
`default_nettype none

module illt_datapath #(
    parameter int NODES = 1024
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  illt_pkg::t_ctl_cmd               i_ctl,
    output illt_pkg::t_ctl_stat              o_stat,
    input  wire                              i_cfg_wr_en,
    input  wire [illt_pkg::SIZE_W-1:0]       i_cfg_wr_data,
    input  wire                              i_cmd,
    input  wire [illt_pkg::SLOT_W-1:0]       i_slot_index,
    input  wire                              i_out_stall,
    output logic                             o_out_valid,
    output logic [1:0]                       o_status,
    output logic [illt_pkg::COUNT_W-1:0]     o_member_count
);
    import illt_pkg::*;

    localparam int LW = $clog2(NODES);
    localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;
    localparam logic [LW-1:0] LAST = LW'(NODES - 1);

    logic [LW-1:0] r_next_mem [NODES];
    logic [LW-1:0] r_prev_mem [NODES];

    logic [SIZE_W-1:0]  r_active_size;
    logic [LW-1:0]      r_clr;
    logic [LW-1:0]      r_head;
    logic [LW-1:0]      r_tail;
    logic [CW-1:0]      r_members;
    logic               r_out_valid;

    logic               r_cmd;
    logic [LW-1:0]      r_idx;
    logic               r_bad;
    logic [LW-1:0]      r_next_q;
    logic [LW-1:0]      r_prev_q;
    logic [1:0]         r_status;
    logic [1:0]         r_out_status;
    logic [COUNT_W-1:0] r_out_count;

    logic [31:0]        w_idx32;
    logic [LW-1:0]      w_rd_addr;
    logic               w_bad;
    logic               w_linked;
    logic [1:0]         w_status;

    logic               w_nx_en;
    logic [LW-1:0]      w_nx_addr;
    logic [LW-1:0]      w_nx_data;
    logic               w_pv_en;
    logic [LW-1:0]      w_pv_addr;
    logic [LW-1:0]      w_pv_data;

    assign w_idx32   = 32'(i_slot_index);
    assign w_rd_addr = w_idx32[LW-1:0];
    assign w_bad     = (i_slot_index == '0)
                    || ({1'b0, i_slot_index} >= r_active_size)
                    || (w_idx32 >= 32'(NODES));

    // Sentinel links live in r_head / r_tail
    assign w_linked = ((r_next_q != '0) || (r_tail == r_idx))
                   && ((r_prev_q != '0) || (r_head == r_idx));

    always_comb begin
        if (r_bad)                  w_status = ST_RANGE;
        else if (r_cmd == CMD_INSERT) w_status = w_linked ? ST_LINK : ST_DONE;
        else                        w_status = w_linked ? ST_DONE : ST_LINK;
    end

    // Write ports; the order of the two steps keeps the last writer of each entry
    always_comb begin
        w_nx_en = 1'b0; w_nx_addr = '0; w_nx_data = '0;
        w_pv_en = 1'b0; w_pv_addr = '0; w_pv_data = '0;
        if (i_ctl.clr) begin
            w_nx_en = 1'b1; w_nx_addr = r_clr;
            w_pv_en = 1'b1; w_pv_addr = r_clr;
        end else if (i_ctl.step1) begin
            w_nx_en = 1'b1;
            w_pv_en = 1'b1;
            if (r_cmd == CMD_INSERT) begin
                w_nx_addr = r_idx;    w_nx_data = r_head;
                w_pv_addr = r_head;   w_pv_data = r_idx;
            end else begin
                w_nx_addr = r_prev_q; w_nx_data = r_next_q;
                w_pv_addr = r_next_q; w_pv_data = r_prev_q;
            end
        end else if (i_ctl.step2) begin
            w_nx_en = 1'b1;
            w_pv_en = 1'b1;
            w_pv_addr = r_idx;
            if (r_cmd == CMD_INSERT) begin
                w_nx_addr = '0;       w_nx_data = r_idx;
            end else begin
                w_nx_addr = r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_nx_en) r_next_mem[w_nx_addr] <= w_nx_data;
        if (w_pv_en) r_prev_mem[w_pv_addr] <= w_pv_data;
        if (i_ctl.accept) begin
            r_next_q <= r_next_mem[w_rd_addr];
            r_prev_q <= r_prev_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_size <= ACTIVE_SIZE_RST;
            r_clr         <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_members     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_active_size <= i_cfg_wr_data;
            if (i_ctl.clr)   r_clr <= r_clr + LW'(1);
            if (w_nx_en && (w_nx_addr == '0)) r_head <= w_nx_data;
            if (w_pv_en && (w_pv_addr == '0)) r_tail <= w_pv_data;
            if (i_ctl.step1) begin
                if (r_cmd == CMD_INSERT)   r_members <= r_members + CW'(1);
                else if (r_members != '0)  r_members <= r_members - CW'(1);
            end
            if (i_ctl.load_out)    r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd <= i_cmd;
            r_idx <= w_rd_addr;
            r_bad <= w_bad;
        end
        if (i_ctl.check) r_status <= w_status;
        if (i_ctl.load_out) begin
            r_out_status <= r_status;
            r_out_count  <= r_members[COUNT_W-1:0];
        end
    end

    assign o_stat.clr_last = (r_clr == LAST);
    assign o_stat.fail     = (w_status != ST_DONE);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_member_count = r_out_count;

endmodule

`default_nettype wire

// ----- rtl/indexed_linked_list_table.sv -----
// Indexed linked-list table: a circular doubly linked membership list over
// NODES slots, slot 0 the sentinel. Each input word inserts a slot at the
// head (i_cmd = 0) or removes it (i_cmd = 1); each gives one result word
// with a status (done, index out of range, already linked / not linked)
// and the member count after the operation.
// Input channel: i_in_valid / o_in_stall, word taken when valid and not stall.
// Output channel: o_out_valid / i_out_stall, same rule; the result sits in an
// output register, so a stalled result does not block the next input word.
// Configuration: i_cfg_wr_en / i_cfg_wr_data writes active_size; write it
// only while no word is in flight.
// Sequence: each word passes the accept, check and result states; a linking
// or unlinking word also passes a second write state, as each link memory has
// a single write port (two writes per memory) and a registered read.
// Reset: a clearing pass zeroes both link memories, one slot per cycle, with
// o_in_stall high; active_size returns to 1024.
// If the result waits on i_out_stall, the next word is still checked and
// linked, then held until the output register frees.
`default_nettype none

module indexed_linked_list_table #(
    parameter int NODES = 1024
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_wr_en,
    input  wire [illt_pkg::SIZE_W-1:0]    i_cfg_wr_data,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire                           i_cmd,
    input  wire [illt_pkg::SLOT_W-1:0]    i_slot_index,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic [1:0]                    o_status,
    output logic [illt_pkg::COUNT_W-1:0]  o_member_count
);
    import illt_pkg::*;

    `include "indexed_linked_list_table_defines.svh"

    t_ctl_cmd  w_cmd;
    t_ctl_stat w_stat;

    // Sequencer: clear pass, then accept / check / write / deliver
    illt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Link memories, sentinel links, count and output register
    illt_datapath #(
        .NODES (NODES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_cmd          (i_cmd),
        .i_slot_index   (i_slot_index),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_member_count (o_member_count)
    );

    // A taken word blocks the input until its result is produced
    `ILLT_ASSERT_NEXT(a_accept_then_stall, i_in_valid && !o_in_stall, o_in_stall)
    // First link writes are always followed by the second pair
    `ILLT_ASSERT_NEXT(a_step1_then_step2, w_cmd.step1, w_cmd.step2)
    // Never overwrite a result that is still waiting
    `ILLT_ASSERT_NOW(a_load_when_free, w_cmd.load_out, w_stat.out_free)
    // No word is taken during the clearing pass
    `ILLT_ASSERT_NOW(a_clear_blocks_input, w_cmd.clr, o_in_stall)

endmodule

`default_nettype wire
